// ===== hdl/deque_with_search_core_macros.svh =====
// ----------------------------------------------------------------------------
// Deque with search: assertion macros
// Concurrent assertion helpers, compiled out for synthesis.
// ----------------------------------------------------------------------------
`ifndef DEQUE_WITH_SEARCH_CORE_MACROS_SVH
`define DEQUE_WITH_SEARCH_CORE_MACROS_SVH

`ifndef SYNTHESIS

// Same-cycle implication, disabled during reset.
`define DWS_ASSERT_IMP(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("deque_with_search_core: assertion failed");

// Next-cycle implication, disabled during reset.
`define DWS_ASSERT_NEXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("deque_with_search_core: assertion failed");

`else

`define DWS_ASSERT_IMP(label, clk, rst, ante, cons)
`define DWS_ASSERT_NEXT(label, clk, rst, ante, cons)

`endif

`endif

// ===== hdl/dws_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Deque with search: shared package
// Request and result formats, command and result codes, and the command and
// status bundles between the controller and the datapath.
// ----------------------------------------------------------------------------
package dws_pkg;

  localparam int DEPTH_DEF = 64;
  localparam int DATA_W    = 32;

  // Command codes carried in a request.
  localparam logic [2:0] CMD_PUSH_HEAD = 3'd0;
  localparam logic [2:0] CMD_PUSH_TAIL = 3'd1;
  localparam logic [2:0] CMD_POP_HEAD  = 3'd2;
  localparam logic [2:0] CMD_POP_TAIL  = 3'd3;
  localparam logic [2:0] CMD_SEARCH    = 3'd4;
  localparam logic [2:0] CMD_DUMP      = 3'd5;

  // Result kinds.
  localparam logic [2:0] KIND_EMPTY     = 3'd0;
  localparam logic [2:0] KIND_FOUND     = 3'd1;
  localparam logic [2:0] KIND_NOT_FOUND = 3'd2;
  localparam logic [2:0] KIND_ELEMENT   = 3'd3;
  localparam logic [2:0] KIND_FULL      = 3'd4;

  typedef struct packed {
    logic [2:0]               cmd;
    logic signed [DATA_W-1:0] value;
  } req_t;

  typedef struct packed {
    logic [2:0]               kind;
    logic signed [DATA_W-1:0] element;
    logic                     last;
  } rsp_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic       push_head;
    logic       push_tail;
    logic       pop_head;
    logic       pop_tail;
    logic       start;
    logic       rd;
    logic       emit;
    logic [2:0] kind;
    logic       last;
  } ctl_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic full;
    logic empty;
    logic match;
    logic at_last;
    logic out_free;
  } sts_t;

endpackage

// ===== hdl/deque_with_search_core.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Deque with search: top level
// Bounded double-ended queue of signed 32-bit values in a ring buffer, with
// push and pop at both ends, a search for a value, and a dump of all entries.
// ----------------------------------------------------------------------------
//
//   Channel  Signals                    Direction  Contents
//   req      req_valid, req_stall, req  in         cmd, value
//   rsp      rsp_valid, rsp_stall, rsp  out        kind, element, last
//
// Pushes and pops finish in the cycle they are accepted; a dropped push or a
// search or dump of an empty queue goes through S_ONE for its result. Search
// and dump walk the storage RAM's single read port, one entry a cycle.
// Reset clears head, occupancy, rsp_valid and the FSM; storage needs no clearing.
// A stalled result holds the walk in place until the output register frees.
// ----------------------------------------------------------------------------
`include "deque_with_search_core_macros.svh"

module deque_with_search_core #(
  parameter int DEPTH = dws_pkg::DEPTH_DEF
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          req_valid,
  output logic          req_stall,
  input  dws_pkg::req_t req,
  output logic          rsp_valid,
  input  logic          rsp_stall,
  output dws_pkg::rsp_t rsp
);

  import dws_pkg::*;

  ctl_t ctl;
  sts_t sts;

  dws_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .req_valid (req_valid),
    .req_cmd   (req.cmd),
    .req_stall (req_stall),
    .ctl       (ctl),
    .sts       (sts)
  );

  dws_datapath #(
    .DEPTH (DEPTH)
  ) u_datapath (
    .clk       (clk),
    .rst       (rst),
    .req       (req),
    .ctl       (ctl),
    .sts       (sts),
    .rsp_valid (rsp_valid),
    .rsp_stall (rsp_stall),
    .rsp       (rsp)
  );

  // A search always produces a result, so the block is busy right after it.
  `DWS_ASSERT_NEXT(a_search_busy, clk, rst, req_valid && !req_stall && req.cmd == CMD_SEARCH, req_stall)

  // Pops finish in the cycle they are accepted.
  `DWS_ASSERT_NEXT(a_pop_single, clk, rst, req_valid && !req_stall && (req.cmd == CMD_POP_HEAD || req.cmd == CMD_POP_TAIL), !req_stall)

  // Only dump elements may be followed by more results from the same request.
  `DWS_ASSERT_IMP(a_last_kind, clk, rst, rsp_valid && !rsp.last, rsp.kind == KIND_ELEMENT)

  // While a walk is in progress no new request is taken.
  `DWS_ASSERT_IMP(a_walk_stalls, clk, rst, ctl.rd, req_stall)

endmodule

// ===== hdl/dws_ram.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Deque with search: generic RAM
// One write port and one read port with registered read data.
// ----------------------------------------------------------------------------
module dws_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic                     rd_en,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write port.
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  // Read port; the data holds while no read is issued.
  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

// ===== hdl/dws_datapath.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Deque with search: datapath
// Ring buffer storage, head and occupancy registers, the walk pointer used by
// search and dump, and the result output register.
// ----------------------------------------------------------------------------
module dws_datapath #(
  parameter int DEPTH = dws_pkg::DEPTH_DEF
) (
  input  logic          clk,
  input  logic          rst,
  input  dws_pkg::req_t req,
  input  dws_pkg::ctl_t ctl,
  output dws_pkg::sts_t sts,
  output logic          rsp_valid,
  input  logic          rsp_stall,
  output dws_pkg::rsp_t rsp
);

  import dws_pkg::*;

  localparam int IDX_W = $clog2(DEPTH);
  localparam int CNT_W = $clog2(DEPTH + 1);

  logic [IDX_W-1:0]  head;
  logic [CNT_W-1:0]  occ;
  logic [IDX_W-1:0]  walk_addr;
  logic [IDX_W-1:0]  cnt;
  logic [DATA_W-1:0] value_q;
  logic [DATA_W-1:0] rd_data;

  logic [IDX_W-1:0]  head_prev;
  logic [IDX_W-1:0]  head_succ;
  logic [IDX_W-1:0]  walk_succ;
  logic [IDX_W:0]    tail_sum;
  logic [IDX_W-1:0]  tail_addr;
  logic [IDX_W-1:0]  wr_addr;
  logic              wr_en;

  // Ring index arithmetic, wrapping at DEPTH.
  assign head_prev = (head == '0) ? IDX_W'(DEPTH - 1) : head - IDX_W'(1);
  assign head_succ = (head == IDX_W'(DEPTH - 1)) ? '0 : head + IDX_W'(1);
  assign walk_succ = (walk_addr == IDX_W'(DEPTH - 1)) ? '0 : walk_addr + IDX_W'(1);

  // The slot just past the tail; head and occupancy are both below DEPTH here.
  assign tail_sum  = (IDX_W + 1)'(head) + (IDX_W + 1)'(occ);
  assign tail_addr = (tail_sum >= (IDX_W + 1)'(DEPTH)) ?
                     IDX_W'(tail_sum - (IDX_W + 1)'(DEPTH)) : IDX_W'(tail_sum);

  assign wr_en   = ctl.push_head | ctl.push_tail;
  assign wr_addr = ctl.push_head ? head_prev : tail_addr;

  dws_ram #(
    .WIDTH (DATA_W),
    .DEPTH (DEPTH)
  ) u_slots (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (wr_addr),
    .wr_data (req.value),
    .rd_en   (ctl.rd),
    .rd_addr (walk_addr),
    .rd_data (rd_data)
  );

  // Head, occupancy and result valid.
  always_ff @(posedge clk) begin
    if (rst) begin
      head      <= '0;
      occ       <= '0;
      rsp_valid <= 1'b0;
    end else begin
      if (ctl.push_head) begin
        head <= head_prev;
        occ  <= occ + CNT_W'(1);
      end else if (ctl.push_tail) begin
        occ  <= occ + CNT_W'(1);
      end else if (ctl.pop_head) begin
        head <= head_succ;
        occ  <= occ - CNT_W'(1);
      end else if (ctl.pop_tail) begin
        occ  <= occ - CNT_W'(1);
      end
      if (ctl.emit) begin
        rsp_valid <= 1'b1;
      end else if (!rsp_stall) begin
        rsp_valid <= 1'b0;
      end
    end
  end

  // Walk state and result payload. The offset counter starts at all ones so
  // that the first read brings it to zero, matching the element in rd_data.
  always_ff @(posedge clk) begin
    if (ctl.start) begin
      value_q   <= req.value;
      walk_addr <= head;
      cnt       <= '1;
    end else if (ctl.rd) begin
      walk_addr <= walk_succ;
      cnt       <= cnt + IDX_W'(1);
    end
    if (ctl.emit) begin
      rsp.kind    <= ctl.kind;
      rsp.element <= (ctl.kind == KIND_ELEMENT) ? rd_data : '0;
      rsp.last    <= ctl.last;
    end
  end

  // Status toward the controller.
  assign sts.full     = (occ == CNT_W'(DEPTH));
  assign sts.empty    = (occ == '0);
  assign sts.match    = (rd_data == value_q);
  assign sts.at_last  = ((CNT_W'(cnt) + CNT_W'(1)) == occ);
  assign sts.out_free = !rsp_valid || !rsp_stall;

endmodule

// ===== hdl/dws_ctrl.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Deque with search: controller
// Decodes each request and sequences single results and the walks of search
// and dump over the stored entries.
// ----------------------------------------------------------------------------
module dws_ctrl (
  input  logic          clk,
  input  logic          rst,
  input  logic          req_valid,
  input  logic [2:0]    req_cmd,
  output logic          req_stall,
  output dws_pkg::ctl_t ctl,
  input  dws_pkg::sts_t sts
);

  import dws_pkg::*;

  typedef enum logic [1:0] {
    S_IDLE,
    S_ONE,
    S_READ,
    S_CHECK
  } state_t;

  state_t     state;
  state_t     state_next;
  logic [2:0] kind_q;
  logic [2:0] kind_next;
  logic       is_dump;
  logic       is_dump_next;

  // Command decode and next state.
  always_comb begin
    ctl          = '0;
    state_next   = state;
    kind_next    = kind_q;
    is_dump_next = is_dump;
    req_stall    = (state != S_IDLE);
    unique case (state)
      S_IDLE: begin
        if (req_valid) begin
          case (req_cmd)
            CMD_PUSH_HEAD, CMD_PUSH_TAIL: begin
              if (sts.full) begin
                kind_next  = KIND_FULL;
                state_next = S_ONE;
              end else begin
                ctl.push_head = (req_cmd == CMD_PUSH_HEAD);
                ctl.push_tail = (req_cmd == CMD_PUSH_TAIL);
              end
            end
            CMD_POP_HEAD: begin
              ctl.pop_head = !sts.empty;
            end
            CMD_POP_TAIL: begin
              ctl.pop_tail = !sts.empty;
            end
            CMD_SEARCH, CMD_DUMP: begin
              if (sts.empty) begin
                kind_next  = KIND_EMPTY;
                state_next = S_ONE;
              end else begin
                ctl.start    = 1'b1;
                is_dump_next = (req_cmd == CMD_DUMP);
                state_next   = S_READ;
              end
            end
            default: begin
            end
          endcase
        end
      end
      S_ONE: begin
        if (sts.out_free) begin
          ctl.emit   = 1'b1;
          ctl.kind   = kind_q;
          ctl.last   = 1'b1;
          state_next = S_IDLE;
        end
      end
      S_READ: begin
        ctl.rd     = 1'b1;
        state_next = S_CHECK;
      end
      S_CHECK: begin
        if (!is_dump) begin
          // Search: stop on a match or after the tail entry.
          if (sts.match || sts.at_last) begin
            if (sts.out_free) begin
              ctl.emit   = 1'b1;
              ctl.kind   = sts.match ? KIND_FOUND : KIND_NOT_FOUND;
              ctl.last   = 1'b1;
              state_next = S_IDLE;
            end
          end else begin
            ctl.rd = 1'b1;
          end
        end else if (sts.out_free) begin
          // Dump: one element per cycle while the output takes them.
          ctl.emit = 1'b1;
          ctl.kind = KIND_ELEMENT;
          ctl.last = sts.at_last;
          if (sts.at_last) begin
            state_next = S_IDLE;
          end else begin
            ctl.rd = 1'b1;
          end
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  // State and registered decode results.
  always_ff @(posedge clk) begin
    if (rst) begin
      state   <= S_IDLE;
      kind_q  <= KIND_EMPTY;
      is_dump <= 1'b0;
    end else begin
      state   <= state_next;
      kind_q  <= kind_next;
      is_dump <= is_dump_next;
    end
  end

endmodule
